### hdl/body_gesture_hysteresis_detector_defines.svh
// ----------------------------------------------------------------------------
// body gesture hysteresis detector assertion macros
// shared assertion forms for the detector rtl
// ----------------------------------------------------------------------------
`ifndef BODY_GESTURE_HYSTERESIS_DETECTOR_DEFINES_SVH
`define BODY_GESTURE_HYSTERESIS_DETECTOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define BGHD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define BGHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bghd_pkg.sv
// ----------------------------------------------------------------------------
// bghd_pkg
// shared types, widths, register indexes and reset values of the detector
// ----------------------------------------------------------------------------
package bghd_pkg;

  // field widths
  localparam int unsigned POS_W     = 13;
  localparam int unsigned HGT_W     = 12;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CAL_W     = 11;
  localparam int unsigned THR_W     = 12;
  localparam int unsigned COOL_W    = 16;
  localparam int unsigned LANE_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // default calibration depth limit
  localparam int unsigned DEF_MAX_CALIB = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_FRAMES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_COOLDOWN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROUCH_THRESH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_ENTER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_EXIT     = 3'd5;

  // register reset values
  localparam logic [CAL_W-1:0]  RST_CALIB_FRAMES  = 11'd30;
  localparam logic [THR_W-1:0]  RST_JUMP_THRESH   = 12'd150;
  localparam logic [COOL_W-1:0] RST_JUMP_COOLDOWN = 16'd300;
  localparam logic [THR_W-1:0]  RST_CROUCH_THRESH = 12'd150;
  localparam logic [THR_W-1:0]  RST_LANE_ENTER    = 12'd250;
  localparam logic [THR_W-1:0]  RST_LANE_EXIT     = 12'd150;

  // lane codes, two's complement
  localparam logic [LANE_W-1:0] LANE_LEFT   = 2'b11;
  localparam logic [LANE_W-1:0] LANE_CENTRE = 2'b00;
  localparam logic [LANE_W-1:0] LANE_RIGHT  = 2'b01;

  // detection thresholds
  typedef struct packed {
    logic [THR_W-1:0]  rise_min;
    logic [COOL_W-1:0] rise_gap_ms;
    logic [THR_W-1:0]  drop_min;
    logic [THR_W-1:0]  side_in;
    logic [THR_W-1:0]  side_out;
  } bghd_thr_t;

  // tracking state carried from frame to frame
  typedef struct packed {
    logic              airborne;
    logic              crouch_held;
    logic [LANE_W-1:0] lane;
    logic [TIME_W-1:0] last_jump;
    logic              jump_seen;
  } bghd_st_t;

  // event flags of one frame
  typedef struct packed {
    logic jump;
    logic crouch_on;
    logic crouch_off;
    logic step_left;
    logic step_right;
  } bghd_evt_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } bghd_div_stat_t;

endpackage

### hdl/bghd_div.sv
// ----------------------------------------------------------------------------
// bghd_div
// restoring serial divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module bghd_div #(
  parameter int unsigned DVD_W = 24,
  parameter int unsigned DVS_W = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DVD_W-1:0]       dividend,
  input  logic [DVS_W-1:0]       divisor,
  output bghd_pkg::bghd_div_stat_t stat,
  output logic [DVD_W-1:0]       quotient
);

  localparam int unsigned ITER_W = $clog2(DVD_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [DVD_W-1:0]    acc_r, acc_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DVS_W:0]      rem_sh;
  logic [DVS_W:0]      rem_sub;
  logic                fits;

  // one trial subtraction of the shifted remainder
  assign rem_sh  = {rem_r, acc_r[DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      acc_nxt  = {acc_r[DVD_W-2:0], fits};
      rem_nxt  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      iter_nxt = iter_r - 1'b1;
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = ITER_W'(DVD_W);
      acc_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = acc_r;

endmodule

### hdl/bghd_detect.sv
// ----------------------------------------------------------------------------
// bghd_detect
// jump, crouch and lane decisions of one frame against the baseline
// ----------------------------------------------------------------------------
module bghd_detect (
  input  logic signed [bghd_pkg::POS_W-1:0]  pos_x,
  input  logic [bghd_pkg::HGT_W-1:0]         body_height,
  input  logic [bghd_pkg::TIME_W-1:0]        time_ms,
  input  logic signed [bghd_pkg::POS_W-1:0]  base_pos,
  input  logic [bghd_pkg::HGT_W-1:0]         base_hgt,
  input  bghd_pkg::bghd_thr_t                thr,
  input  bghd_pkg::bghd_st_t                 st,
  output bghd_pkg::bghd_st_t                 st_nxt,
  output bghd_pkg::bghd_evt_t                evt
);

  localparam int unsigned CW = 18;

  logic signed [bghd_pkg::HGT_W:0] rel_h;
  logic signed [bghd_pkg::POS_W:0] rel_x;
  logic signed [CW-1:0]            rh, rx, rh2, rh10;
  logic signed [CW-1:0]            jt, ct, ct7, le, lx;
  logic [bghd_pkg::TIME_W-1:0]     dt;
  logic                            cool_ok;

  // offsets from the baseline
  assign rel_h = $signed({1'b0, body_height}) - $signed({1'b0, base_hgt});
  assign rel_x = (bghd_pkg::POS_W+1)'(pos_x) - (bghd_pkg::POS_W+1)'(base_pos);

  // widen for exact compares
  assign rh   = CW'(rel_h);
  assign rx   = CW'(rel_x);
  assign rh2  = rh <<< 1;
  assign rh10 = (rh <<< 3) + (rh <<< 1);
  assign jt   = $signed({{(CW-bghd_pkg::THR_W){1'b0}}, thr.rise_min});
  assign ct   = $signed({{(CW-bghd_pkg::THR_W){1'b0}}, thr.drop_min});
  assign ct7  = (ct <<< 3) - ct;
  assign le   = $signed({{(CW-bghd_pkg::THR_W){1'b0}}, thr.side_in});
  assign lx   = $signed({{(CW-bghd_pkg::THR_W){1'b0}}, thr.side_out});

  // cooldown since the last reported jump, modulo 2^32
  assign dt      = time_ms - st.last_jump;
  assign cool_ok = !st.jump_seen ||
                   (dt >= {{(bghd_pkg::TIME_W-bghd_pkg::COOL_W){1'b0}}, thr.rise_gap_ms});

  always_comb begin
    st_nxt = st;
    evt    = '0;

    // jump rise with cooldown, release below half threshold
    if (!st.airborne && (rh > jt)) begin
      st_nxt.airborne = 1'b1;
      if (cool_ok) begin
        evt.jump         = 1'b1;
        st_nxt.last_jump = time_ms;
        st_nxt.jump_seen = 1'b1;
      end
    end else if (st.airborne && (rh2 < jt)) begin
      st_nxt.airborne = 1'b0;
    end

    // crouch hysteresis, release at 0.7 of threshold
    if (!st.crouch_held && (rh < -ct)) begin
      st_nxt.crouch_held = 1'b1;
      evt.crouch_on      = 1'b1;
    end else if (st.crouch_held && (rh10 > -ct7)) begin
      st_nxt.crouch_held = 1'b0;
      evt.crouch_off     = 1'b1;
    end

    // lane enter and exit hysteresis
    unique case (st.lane)
      bghd_pkg::LANE_CENTRE: begin
        if (rx < -le) begin
          st_nxt.lane   = bghd_pkg::LANE_LEFT;
          evt.step_left = 1'b1;
        end else if (rx > le) begin
          st_nxt.lane    = bghd_pkg::LANE_RIGHT;
          evt.step_right = 1'b1;
        end
      end
      bghd_pkg::LANE_LEFT: begin
        if (rx > -lx) begin
          st_nxt.lane    = bghd_pkg::LANE_CENTRE;
          evt.step_right = 1'b1;
        end
      end
      bghd_pkg::LANE_RIGHT: begin
        if (rx < lx) begin
          st_nxt.lane   = bghd_pkg::LANE_CENTRE;
          evt.step_left = 1'b1;
        end
      end
      default: begin
        st_nxt.lane = st.lane;
      end
    endcase
  end

endmodule

### hdl/body_gesture_hysteresis_detector.sv
// ----------------------------------------------------------------------------
// body_gesture_hysteresis_detector
// per-frame jump, crouch and lane detection after a baseline calibration
//
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    pos_x, body_height, time_ms
// out_     output     out_valid / out_ready  event flags, current_lane, crouching
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a frame passes through the EXEC and FIN states to the output register, one item at
// a time, so a new frame is taken only once the last is in the output register;
// the frame that ends calibration runs the serial divider twice, for the
// position sum in DIVP and then the height sum in DIVH.
// reset is synchronous, active low, and clears all control and tracking state.
// a waiting result holds in the output register; the next frame is taken
// while it waits and stalls only before its own result is loaded.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "body_gesture_hysteresis_detector_defines.svh"

module body_gesture_hysteresis_detector #(
  parameter int unsigned MAX_CALIB = bghd_pkg::DEF_MAX_CALIB
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bghd_pkg::POS_W-1:0]     in_pos_x,
  input  logic [bghd_pkg::HGT_W-1:0]            in_body_height,
  input  logic [bghd_pkg::TIME_W-1:0]           in_time_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_calibrating,
  output logic                                  out_jump,
  output logic                                  out_crouch_start,
  output logic                                  out_crouch_end,
  output logic                                  out_lane_left,
  output logic                                  out_lane_right,
  output logic signed [bghd_pkg::LANE_W-1:0]    out_current_lane,
  output logic                                  out_crouching,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bghd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bghd_pkg::CFG_DAT_W-1:0]        cfg_data
);

  localparam int unsigned CNT_W  = $clog2(MAX_CALIB + 1);
  localparam int unsigned SUMP_W = bghd_pkg::POS_W + CNT_W;
  localparam int unsigned SUMH_W = bghd_pkg::HGT_W + CNT_W;
  localparam int unsigned DVD_W  = SUMP_W;
  localparam int unsigned CMP_W  = (CNT_W > bghd_pkg::CAL_W) ? CNT_W : bghd_pkg::CAL_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DIVP = 3'd2;
  localparam logic [2:0] ST_DIVH = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                          state_r, state_nxt;

  // configuration registers
  logic [bghd_pkg::CAL_W-1:0]          calib_frames_r;
  bghd_pkg::bghd_thr_t                 thr_r;

  // captured frame
  logic signed [bghd_pkg::POS_W-1:0]   pos_x_r;
  logic [bghd_pkg::HGT_W-1:0]          height_r;
  logic [bghd_pkg::TIME_W-1:0]         time_r;

  // calibration state
  logic                                calibrated_r, calibrated_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic signed [SUMP_W-1:0]            sum_pos_r, sum_pos_nxt;
  logic [SUMH_W-1:0]                   sum_hgt_r, sum_hgt_nxt;
  logic signed [bghd_pkg::POS_W-1:0]   base_pos_r, base_pos_nxt;
  logic [bghd_pkg::HGT_W-1:0]          base_hgt_r, base_hgt_nxt;
  logic                                pos_neg_r, pos_neg_nxt;

  // tracking state and pending result
  bghd_pkg::bghd_st_t                  trk_r, trk_nxt, det_st;
  bghd_pkg::bghd_evt_t                 det_evt;
  bghd_pkg::bghd_evt_t                 res_evt_r, res_evt_nxt;
  logic                                res_cal_r, res_cal_nxt;

  // output register
  logic                                out_valid_r, out_valid_nxt;
  bghd_pkg::bghd_evt_t                 out_evt_r, out_evt_nxt;
  logic                                out_cal_r, out_cal_nxt;
  logic [bghd_pkg::LANE_W-1:0]         out_lane_r, out_lane_nxt;
  logic                                out_crouch_r, out_crouch_nxt;

  // divider hookup
  logic                                div_start;
  logic [DVD_W-1:0]                    div_dvd;
  logic [CNT_W-1:0]                    div_dvs;
  bghd_pkg::bghd_div_stat_t            div_stat;
  logic [DVD_W-1:0]                    div_q;

  // calibration length and completion test
  logic [CMP_W-1:0]                    cal_w, cal_max, cal_target;
  logic [CNT_W-1:0]                    cnt_inc;
  logic                                cal_done;
  logic signed [SUMP_W-1:0]            sum_pos_acc;
  logic [SUMP_W-1:0]                   sum_pos_mag;
  logic [bghd_pkg::POS_W-1:0]          q_pos;
  logic                                lane_legal;

  assign cal_w      = CMP_W'(calib_frames_r);
  assign cal_max    = CMP_W'(MAX_CALIB);
  assign cal_target = (cal_w > cal_max) ? cal_max :
                      ((cal_w == '0) ? CMP_W'(1) : cal_w);
  assign cnt_inc    = cnt_r + 1'b1;
  assign cal_done   = CMP_W'(cnt_inc) >= cal_target;
  assign sum_pos_acc = sum_pos_r + SUMP_W'(pos_x_r);
  assign sum_pos_mag = sum_pos_acc[SUMP_W-1] ? (SUMP_W'(0) - sum_pos_acc) : sum_pos_acc;
  assign q_pos       = div_q[bghd_pkg::POS_W-1:0];

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_frames_r    <= bghd_pkg::RST_CALIB_FRAMES;
      thr_r.rise_min    <= bghd_pkg::RST_JUMP_THRESH;
      thr_r.rise_gap_ms <= bghd_pkg::RST_JUMP_COOLDOWN;
      thr_r.drop_min    <= bghd_pkg::RST_CROUCH_THRESH;
      thr_r.side_in     <= bghd_pkg::RST_LANE_ENTER;
      thr_r.side_out    <= bghd_pkg::RST_LANE_EXIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bghd_pkg::REG_CALIB_FRAMES:  calib_frames_r    <= cfg_data[bghd_pkg::CAL_W-1:0];
        bghd_pkg::REG_JUMP_THRESH:   thr_r.rise_min    <= cfg_data[bghd_pkg::THR_W-1:0];
        bghd_pkg::REG_JUMP_COOLDOWN: thr_r.rise_gap_ms <= cfg_data;
        bghd_pkg::REG_CROUCH_THRESH: thr_r.drop_min    <= cfg_data[bghd_pkg::THR_W-1:0];
        bghd_pkg::REG_LANE_ENTER:    thr_r.side_in     <= cfg_data[bghd_pkg::THR_W-1:0];
        bghd_pkg::REG_LANE_EXIT:     thr_r.side_out    <= cfg_data[bghd_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frame capture
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_x_r  <= in_pos_x;
      height_r <= in_body_height;
      time_r   <= in_time_ms;
    end
  end

  // event logic
  bghd_detect u_detect (
    .pos_x       (pos_x_r),
    .body_height (height_r),
    .time_ms     (time_r),
    .base_pos    (base_pos_r),
    .base_hgt    (base_hgt_r),
    .thr         (thr_r),
    .st          (trk_r),
    .st_nxt      (det_st),
    .evt         (det_evt)
  );

  // shared serial divider for the baseline
  bghd_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    calibrated_nxt = calibrated_r;
    cnt_nxt        = cnt_r;
    sum_pos_nxt    = sum_pos_r;
    sum_hgt_nxt    = sum_hgt_r;
    base_pos_nxt   = base_pos_r;
    base_hgt_nxt   = base_hgt_r;
    pos_neg_nxt    = pos_neg_r;
    trk_nxt        = trk_r;
    res_evt_nxt    = res_evt_r;
    res_cal_nxt    = res_cal_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_evt_nxt    = out_evt_r;
    out_cal_nxt    = out_cal_r;
    out_lane_nxt   = out_lane_r;
    out_crouch_nxt = out_crouch_r;
    div_start      = 1'b0;
    div_dvd        = sum_pos_mag;
    div_dvs        = cnt_inc;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!calibrated_r) begin
          // accumulate a calibration frame
          sum_pos_nxt = sum_pos_acc;
          sum_hgt_nxt = sum_hgt_r + SUMH_W'(height_r);
          cnt_nxt     = cnt_inc;
          res_cal_nxt = 1'b1;
          res_evt_nxt = '0;
          if (cal_done) begin
            pos_neg_nxt = sum_pos_acc[SUMP_W-1];
            div_start   = 1'b1;
            state_nxt   = ST_DIVP;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          trk_nxt     = det_st;
          res_cal_nxt = 1'b0;
          res_evt_nxt = det_evt;
          state_nxt   = ST_FIN;
        end
      end
      ST_DIVP: begin
        // position quotient, then start the height division
        if (div_stat.done) begin
          base_pos_nxt = pos_neg_r ? $signed(bghd_pkg::POS_W'(0) - q_pos) : $signed(q_pos);
          div_dvd      = DVD_W'(sum_hgt_r);
          div_dvs      = cnt_r;
          div_start    = 1'b1;
          state_nxt    = ST_DIVH;
        end
      end
      ST_DIVH: begin
        if (div_stat.done) begin
          base_hgt_nxt   = div_q[bghd_pkg::HGT_W-1:0];
          calibrated_nxt = 1'b1;
          state_nxt      = ST_FIN;
        end
      end
      ST_FIN: begin
        // load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_evt_nxt    = res_evt_r;
          out_cal_nxt    = res_cal_r;
          out_lane_nxt   = trk_r.lane;
          out_crouch_nxt = trk_r.crouch_held;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and tracking registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      calibrated_r <= 1'b0;
      cnt_r        <= '0;
      sum_pos_r    <= '0;
      sum_hgt_r    <= '0;
      base_pos_r   <= '0;
      base_hgt_r   <= '0;
      trk_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      calibrated_r <= calibrated_nxt;
      cnt_r        <= cnt_nxt;
      sum_pos_r    <= sum_pos_nxt;
      sum_hgt_r    <= sum_hgt_nxt;
      base_pos_r   <= base_pos_nxt;
      base_hgt_r   <= base_hgt_nxt;
      trk_r        <= trk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_neg_r    <= pos_neg_nxt;
    res_evt_r    <= res_evt_nxt;
    res_cal_r    <= res_cal_nxt;
    out_evt_r    <= out_evt_nxt;
    out_cal_r    <= out_cal_nxt;
    out_lane_r   <= out_lane_nxt;
    out_crouch_r <= out_crouch_nxt;
  end

  // output ports
  assign out_valid        = out_valid_r;
  assign out_calibrating  = out_cal_r;
  assign out_jump         = out_evt_r.jump;
  assign out_crouch_start = out_evt_r.crouch_on;
  assign out_crouch_end   = out_evt_r.crouch_off;
  assign out_lane_left    = out_evt_r.step_left;
  assign out_lane_right   = out_evt_r.step_right;
  assign out_current_lane = $signed(out_lane_r);
  assign out_crouching    = out_crouch_r;

  // lane register holds one of the three lane codes
  assign lane_legal = (trk_r.lane == bghd_pkg::LANE_LEFT) ||
                      (trk_r.lane == bghd_pkg::LANE_CENTRE) ||
                      (trk_r.lane == bghd_pkg::LANE_RIGHT);

  // checks
  `BGHD_ASSERT_NEXT(a_one_frame, clk, rst_n, in_valid && in_ready, !in_ready, "frame accepted while busy")
  `BGHD_ASSERT_SAME(a_cal_quiet, clk, rst_n, out_valid && out_calibrating, out_evt_r == '0, "events during calibration")
  `BGHD_ASSERT_SAME(a_lane_code, clk, rst_n, 1'b1, lane_legal, "illegal lane code")
  `BGHD_ASSERT_SAME(a_cnt_max, clk, rst_n, 1'b1, CMP_W'(cnt_r) <= cal_max, "calibration count past limit")
  `BGHD_ASSERT_NEXT(a_cal_end, clk, rst_n, !calibrated_r && !(state_r == ST_DIVH && div_stat.done), !calibrated_r, "calibration ended outside the division")

endmodule

### bench/gesture_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_monitor
// watches the frame, result and register channels of the gesture detector,
// works out the flags of every accepted frame and compares each result, in
// order, with the flags worked out for it
// ----------------------------------------------------------------------------
module gesture_monitor #(
  parameter int unsigned MAX_CALIB = bghd_pkg::DEF_MAX_CALIB
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [bghd_pkg::POS_W-1:0]  in_pos_x,
  input  logic [bghd_pkg::HGT_W-1:0]         in_body_height,
  input  logic [bghd_pkg::TIME_W-1:0]        in_time_ms,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               out_calibrating,
  input  logic                               out_jump,
  input  logic                               out_crouch_start,
  input  logic                               out_crouch_end,
  input  logic                               out_lane_left,
  input  logic                               out_lane_right,
  input  logic signed [bghd_pkg::LANE_W-1:0] out_current_lane,
  input  logic                               out_crouching,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [bghd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bghd_pkg::CFG_DAT_W-1:0]     cfg_data,
  output int                                 mismatch_count,
  output int                                 flags_pending,
  output int                                 results_checked,
  output int                                 event_results
);

  typedef struct packed {
    logic                        calibrating;
    logic                        jump;
    logic                        crouch_on;
    logic                        crouch_off;
    logic                        step_left;
    logic                        step_right;
    logic [bghd_pkg::LANE_W-1:0] lane;
    logic                        crouching;
  } frame_flags_t;

  // flags of accepted frames whose result has not come out yet
  frame_flags_t expected_flags[$];

  // register copies
  logic [bghd_pkg::CAL_W-1:0]  calib_len;
  logic [bghd_pkg::THR_W-1:0]  rise_thr;
  logic [bghd_pkg::COOL_W-1:0] cooldown;
  logic [bghd_pkg::THR_W-1:0]  drop_thr;
  logic [bghd_pkg::THR_W-1:0]  enter_off;
  logic [bghd_pkg::THR_W-1:0]  exit_off;

  // baseline and tracking state
  logic                        baseline_ready;
  int                          frames_summed;
  longint                      pos_total;
  longint                      hgt_total;
  int                          base_pos;
  int                          base_hgt;
  logic                        in_air;
  logic                        crouched;
  logic [bghd_pkg::LANE_W-1:0] lane;
  logic [bghd_pkg::TIME_W-1:0] last_jump;
  logic                        jumped;

  // advances the tracking state by one frame and returns its flags
  function automatic frame_flags_t predict_flags(int px, int h, logic [bghd_pkg::TIME_W-1:0] t);
    frame_flags_t                r;
    int                          target;
    int                          rel_x;
    int                          rel_h;
    int                          jt;
    int                          ct;
    int                          le;
    int                          lx;
    logic [bghd_pkg::TIME_W-1:0] since_jump;
    r = '0;
    if (!baseline_ready) begin
      // calibration: sum, then divide once toward zero on the last frame
      target = (calib_len > MAX_CALIB) ? int'(MAX_CALIB) : int'(calib_len);
      if (target == 0) begin
        target = 1;
      end
      pos_total += px;
      hgt_total += h;
      frames_summed++;
      if (frames_summed >= target) begin
        base_pos = int'(pos_total / longint'(frames_summed));
        base_hgt = int'(hgt_total / longint'(frames_summed));
        baseline_ready = 1'b1;
      end
      r.calibrating = 1'b1;
    end else begin
      rel_x = px - base_pos;
      rel_h = h - base_hgt;
      jt = int'(rise_thr);
      ct = int'(drop_thr);
      le = int'(enter_off);
      lx = int'(exit_off);
      since_jump = t - last_jump;

      // jump rise with cooldown, release below half the threshold
      if (!in_air && rel_h > jt) begin
        if (!jumped || since_jump >= cooldown) begin
          r.jump = 1'b1;
          last_jump = t;
          jumped = 1'b1;
        end
        in_air = 1'b1;
      end else if (in_air && 2 * rel_h < jt) begin
        in_air = 1'b0;
      end

      // crouch hysteresis, release at 0.7 of the threshold
      if (!crouched && rel_h < -ct) begin
        crouched = 1'b1;
        r.crouch_on = 1'b1;
      end else if (crouched && 10 * rel_h > -7 * ct) begin
        crouched = 1'b0;
        r.crouch_off = 1'b1;
      end

      // lane hysteresis
      case (lane)
        bghd_pkg::LANE_CENTRE: begin
          if (rel_x < -le) begin
            lane = bghd_pkg::LANE_LEFT;
            r.step_left = 1'b1;
          end else if (rel_x > le) begin
            lane = bghd_pkg::LANE_RIGHT;
            r.step_right = 1'b1;
          end
        end
        bghd_pkg::LANE_LEFT: begin
          if (rel_x > -lx) begin
            lane = bghd_pkg::LANE_CENTRE;
            r.step_right = 1'b1;
          end
        end
        bghd_pkg::LANE_RIGHT: begin
          if (rel_x < lx) begin
            lane = bghd_pkg::LANE_CENTRE;
            r.step_left = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.lane = lane;
    r.crouching = crouched;
    return r;
  endfunction

  function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // per-edge bookkeeping: results first, then register writes, then new frames
  always @(posedge clk) begin : watch
    frame_flags_t want;
    frame_flags_t fresh;
    if (!rst_n) begin
      calib_len = bghd_pkg::RST_CALIB_FRAMES;
      rise_thr = bghd_pkg::RST_JUMP_THRESH;
      cooldown = bghd_pkg::RST_JUMP_COOLDOWN;
      drop_thr = bghd_pkg::RST_CROUCH_THRESH;
      enter_off = bghd_pkg::RST_LANE_ENTER;
      exit_off = bghd_pkg::RST_LANE_EXIT;
      baseline_ready = 1'b0;
      frames_summed = 0;
      pos_total = 0;
      hgt_total = 0;
      base_pos = 0;
      base_hgt = 0;
      in_air = 1'b0;
      crouched = 1'b0;
      lane = bghd_pkg::LANE_CENTRE;
      last_jump = '0;
      jumped = 1'b0;
      expected_flags.delete();
      mismatch_count = 0;
      results_checked = 0;
      event_results = 0;
    end else begin
      // result transaction
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          $error("result transaction with no frame waiting for it");
          mismatch_count++;
        end else begin
          want = expected_flags.pop_front();
          check_field("out_calibrating", want.calibrating, out_calibrating);
          check_field("out_jump", want.jump, out_jump);
          check_field("out_crouch_start", want.crouch_on, out_crouch_start);
          check_field("out_crouch_end", want.crouch_off, out_crouch_end);
          check_field("out_lane_left", want.step_left, out_lane_left);
          check_field("out_lane_right", want.step_right, out_lane_right);
          check_field("out_current_lane", want.lane, out_current_lane);
          check_field("out_crouching", want.crouching, out_crouching);
          results_checked++;
          if (want.jump || want.crouch_on || want.crouch_off ||
              want.step_left || want.step_right) begin
            event_results++;
          end
        end
      end

      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bghd_pkg::REG_CALIB_FRAMES:  calib_len = cfg_data[bghd_pkg::CAL_W-1:0];
          bghd_pkg::REG_JUMP_THRESH:   rise_thr = cfg_data[bghd_pkg::THR_W-1:0];
          bghd_pkg::REG_JUMP_COOLDOWN: cooldown = cfg_data[bghd_pkg::COOL_W-1:0];
          bghd_pkg::REG_CROUCH_THRESH: drop_thr = cfg_data[bghd_pkg::THR_W-1:0];
          bghd_pkg::REG_LANE_ENTER:    enter_off = cfg_data[bghd_pkg::THR_W-1:0];
          bghd_pkg::REG_LANE_EXIT:     exit_off = cfg_data[bghd_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      // frame transaction
      if (in_valid && in_ready) begin
        fresh = predict_flags(int'(in_pos_x), int'(in_body_height), in_time_ms);
        expected_flags.insert(expected_flags.size(), fresh);
      end
    end
    flags_pending = expected_flags.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives body frames and threshold settings into the gesture detector with
// random gaps and output stalls; a monitor beside the block checks every
// result against flags it works out itself
// ----------------------------------------------------------------------------
module testbench;

  // the directed calibration frames put the baseline here
  localparam int STAND_POS    = -1;
  localparam int STAND_HEIGHT = 2035;
  localparam int PHASES       = 12;
  localparam int PHASE_FRAMES = 157;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [bghd_pkg::POS_W-1:0]   in_pos_x;
  logic [bghd_pkg::HGT_W-1:0]          in_body_height;
  logic [bghd_pkg::TIME_W-1:0]         in_time_ms;
  logic                                out_valid;
  logic                                out_ready;
  logic                                out_calibrating;
  logic                                out_jump;
  logic                                out_crouch_start;
  logic                                out_crouch_end;
  logic                                out_lane_left;
  logic                                out_lane_right;
  logic signed [bghd_pkg::LANE_W-1:0]  out_current_lane;
  logic                                out_crouching;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [bghd_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [bghd_pkg::CFG_DAT_W-1:0]      cfg_data;

  int   mismatch_count;
  int   flags_pending;
  int   results_checked;
  int   event_results;
  int   frames_sent;
  logic quiet;

  body_gesture_hysteresis_detector dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_body_height   (in_body_height),
    .in_time_ms       (in_time_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_calibrating  (out_calibrating),
    .out_jump         (out_jump),
    .out_crouch_start (out_crouch_start),
    .out_crouch_end   (out_crouch_end),
    .out_lane_left    (out_lane_left),
    .out_lane_right   (out_lane_right),
    .out_current_lane (out_current_lane),
    .out_crouching    (out_crouching),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  gesture_monitor monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_body_height   (in_body_height),
    .in_time_ms       (in_time_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_calibrating  (out_calibrating),
    .out_jump         (out_jump),
    .out_crouch_start (out_crouch_start),
    .out_crouch_end   (out_crouch_end),
    .out_lane_left    (out_lane_left),
    .out_lane_right   (out_lane_right),
    .out_current_lane (out_current_lane),
    .out_crouching    (out_crouching),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .flags_pending    (flags_pending),
    .results_checked  (results_checked),
    .event_results    (event_results)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #18_000_000;
    $display("Mismatches found");
    $finish;
  end

  // mostly short gaps, a few long ones, none in quiet phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic int jitter(int centre_val, int spread);
    return centre_val + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // result side backpressure
  initial begin : stall_driver
    int hold;
    int r;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet) begin
        out_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready = 1'b1;
          hold = $urandom_range(0, 5);
        end else if (r < 92) begin
          out_ready = 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // one frame transaction, entered and left at a falling edge
  task automatic send_frame(int px, int h, logic [bghd_pkg::TIME_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (px < -4096) px = -4096;
    if (px > 4095) px = 4095;
    if (h < 0) h = 0;
    if (h > 4095) h = 4095;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pos_x = px[bghd_pkg::POS_W-1:0];
    in_body_height = h[bghd_pkg::HGT_W-1:0];
    in_time_ms = t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    frames_sent++;
  endtask

  task automatic write_reg(logic [bghd_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value[bghd_pkg::CFG_DAT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // every frame has given its result
  task automatic wait_idle();
    in_valid = 1'b0;
    while (flags_pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int                          phase;
    int                          n;
    int                          px;
    int                          h;
    int                          dx;
    int                          dh;
    int                          jt;
    int                          cool;
    int                          ct;
    int                          le;
    int                          lx;
    int                          r;
    logic [bghd_pkg::TIME_W-1:0] now_ms;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_body_height = '0;
    in_time_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = bghd_pkg::REG_CALIB_FRAMES;
    cfg_data = '0;
    quiet = 1'b0;
    frames_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // calibration: over-long length saturates, then zero ends it at once
    write_reg(bghd_pkg::REG_CALIB_FRAMES, 2047);
    send_frame(-4096, 0, 32'h0000_0000);
    send_frame(4095, 4095, 32'hFFFF_FFFF);
    send_frame(-3, 2048, 32'h5555_5555);
    wait_idle();
    write_reg(bghd_pkg::REG_CALIB_FRAMES, 0);
    // sums -6 and 8143 over four frames, divided toward zero
    send_frame(-2, 2000, 32'hAAAA_AAAA);

    // jump edge, landing at half threshold and cooldown, reset thresholds
    send_frame(STAND_POS, STAND_HEIGHT, 1000);
    send_frame(STAND_POS, STAND_HEIGHT + 151, 1010);
    send_frame(STAND_POS, STAND_HEIGHT + 75, 1020);
    send_frame(STAND_POS, STAND_HEIGHT + 74, 1030);
    send_frame(STAND_POS, STAND_HEIGHT + 151, 1100);
    send_frame(STAND_POS, STAND_HEIGHT, 1110);
    send_frame(STAND_POS, STAND_HEIGHT + 151, 1310);
    send_frame(STAND_POS, STAND_HEIGHT, 1320);
    // crouch start just past threshold, end at the 0.7 boundary
    send_frame(STAND_POS, STAND_HEIGHT - 150, 1330);
    send_frame(STAND_POS, STAND_HEIGHT - 151, 1340);
    send_frame(STAND_POS, STAND_HEIGHT - 105, 1350);
    send_frame(STAND_POS, STAND_HEIGHT - 104, 1360);
    // lane enter and exit on both sides, one step either side of each edge but the left entry
    send_frame(STAND_POS + 250, STAND_HEIGHT, 1370);
    send_frame(STAND_POS + 251, STAND_HEIGHT, 1380);
    send_frame(STAND_POS + 150, STAND_HEIGHT, 1390);
    send_frame(STAND_POS + 149, STAND_HEIGHT, 1400);
    send_frame(STAND_POS - 251, STAND_HEIGHT, 1410);
    send_frame(STAND_POS - 150, STAND_HEIGHT, 1420);
    send_frame(STAND_POS - 149, STAND_HEIGHT, 1430);

    // random phases, each with its own thresholds
    now_ms = 1500;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          jt = 0; cool = 0; ct = 0; le = 0; lx = 0;
        end
        1: begin
          jt = 4095; cool = 65535; ct = 4095; le = 4095; lx = 4095;
        end
        2: begin
          jt = 150; cool = 300; ct = 150; le = 250; lx = 150;
        end
        3: begin
          jt = 300; cool = 200; ct = 200; le = 100; lx = 400;
        end
        default: begin
          jt = $urandom_range(20, 600);
          cool = $urandom_range(0, 1000);
          ct = $urandom_range(20, 600);
          le = $urandom_range(50, 900);
          lx = $urandom_range(0, le);
        end
      endcase
      // calibration length has no effect once the baseline is set
      write_reg(bghd_pkg::REG_CALIB_FRAMES, $urandom_range(0, 2047));
      write_reg(bghd_pkg::REG_JUMP_THRESH, jt);
      write_reg(bghd_pkg::REG_JUMP_COOLDOWN, cool);
      write_reg(bghd_pkg::REG_CROUCH_THRESH, ct);
      write_reg(bghd_pkg::REG_LANE_ENTER, le);
      write_reg(bghd_pkg::REG_LANE_EXIT, lx);
      quiet = (phase % 5 == 4);

      for (n = 0; n < PHASE_FRAMES; n++) begin
        // timestamps mostly creep forward, sometimes leap or wrap
        r = $urandom_range(0, 99);
        if (r < 85) begin
          now_ms += $urandom_range(0, 120);
        end else if (r < 97) begin
          now_ms += $urandom_range(0, 70000);
        end else begin
          now_ms = $urandom;
        end

        if ($urandom_range(0, 9) < 2) begin
          // noise over the whole field range
          px = int'($urandom_range(0, 8191)) - 4096;
          h = $urandom_range(0, 4095);
        end else begin
          // body moves around the decision edges of the current thresholds
          case ($urandom_range(0, 9))
            0, 1:    dh = jt + int'($urandom_range(0, 80)) - 2;
            2:       dh = jitter(jt / 2, 2);
            3, 4:    dh = -ct - int'($urandom_range(0, 80)) + 2;
            5:       dh = jitter(-(7 * ct) / 10, 2);
            default: dh = jitter(0, 20);
          endcase
          case ($urandom_range(0, 9))
            0:       dx = jitter(le, 2);
            1:       dx = jitter(-le, 2);
            2:       dx = jitter(lx, 2);
            3:       dx = jitter(-lx, 2);
            4:       dx = le + int'($urandom_range(1, 300));
            5:       dx = -le - int'($urandom_range(1, 300));
            default: dx = jitter(0, 40);
          endcase
          px = STAND_POS + dx;
          h = STAND_HEIGHT + dh;
        end
        send_frame(px, h, now_ms);
      end
    end

    // drain, then let the pipeline settle
    quiet = 1'b0;
    wait_idle();
    repeat (10) @(negedge clk);

    $display("Run covered %0d frames: calibration, directed edges and %0d threshold settings",
             frames_sent, PHASES + 1);
    $display("%0d results compared, %0d of them with a gesture event",
             results_checked, event_results);
    if (mismatch_count == 0 && flags_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
